/* rtl/cxs_pkg.sv */
// ============================================================================
// cxs_pkg
// Shared constants, formats and table builder for the chromaticity to sRGB
// converter.
// ============================================================================
package cxs_pkg;

    // Defaults for the top-level parameters.
    localparam int INPUT_FRAC_BITS_DEF = 15;
    localparam int GAMMA_ADDR_BITS_DEF = 10;

    // Fixed-point formats.
    localparam int CH_W   = 17;   // encoded channel, 0..1.0 in Q16
    localparam int LIN_W  = 27;   // linear channel before normalisation, Q16
    localparam int SUM_W  = 46;   // matrix accumulator, Q32
    localparam int XZ_QW  = 23;   // quotient bits kept for X and Z
    localparam int XZ_W   = 25;   // signed X and Z with room for negation

    localparam logic [CH_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [CH_W-1:0] LIN_LIMIT = 17'd205;
    localparam logic [19:0]     LIN_SLOPE = 20'd846725;

    // XYZ to linear RGB matrix in Q16.
    localparam logic signed [17:0] CR_X = 18'sd108560;
    localparam logic signed [17:0] CR_Z = -18'sd16714;
    localparam logic signed [17:0] CG_X = -18'sd46347;
    localparam logic signed [17:0] CG_Z = 18'sd2369;
    localparam logic signed [17:0] CB_X = 18'sd3389;
    localparam logic signed [17:0] CB_Z = 18'sd66292;

    // The Y column times Y = 1.0 (Q16), already in Q32.
    localparam logic signed [SUM_W-1:0] OFF_R = -46'sd1524105216;
    localparam logic signed [SUM_W-1:0] OFF_G = 46'sd7109869568;
    localparam logic signed [SUM_W-1:0] OFF_B = -46'sd521273344;

    // Magnitude width of x and of 1-x-y for a given input format.
    function automatic int mag_width(input int frac_bits);
        return (frac_bits + 1 > 17) ? frac_bits + 1 : 17;
    endfunction

    // Largest R in 0..2^20 with R^k <= target, k is 2 or 3.
    function automatic longint unsigned root_floor(input longint unsigned target,
                                                   input int k);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        lo = 0;
        hi = 64'd1 << 20;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            p = mid * mid;
            if (k == 3) begin
                p = p * mid;
            end
            if (p <= target) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return lo;
    endfunction

    // One entry of the transfer curve table: 1.055 * t^(5/12) - 0.055 in Q16.
    function automatic logic [CH_W-1:0] gamma_entry(input int idx, input int abits);
        longint unsigned t;
        longint unsigned a;
        longint unsigned b;
        longint unsigned q;
        longint unsigned p;
        longint          g;
        t = longint'(idx) << (20 - abits);
        a = root_floor(t << 40, 3);
        b = root_floor(a << 20, 2);
        q = root_floor(b << 20, 2);
        p = (a * q) >> 20;
        g = longint'((p * 64'd69140) >> 20) - 64'sd3604;
        if (g < 0) begin
            g = 0;
        end
        if (g > 65536) begin
            g = 65536;
        end
        return CH_W'(g);
    endfunction

endpackage

/* rtl/cie_xy_to_srgb_color_top.sv */
// ============================================================================
// cie_xy_to_srgb_color_top
// CIE 1931 xy chromaticity to 8-bit sRGB converter, fully pipelined.
// ============================================================================
// Usage:
// The slave channel takes one word per pixel holding x and y in unsigned
// Q1.INPUT_FRAC_BITS; the master channel returns one word holding the
// gamma-encoded red, green and blue levels. A y of zero gives white.
// Every word passes through 47 register stages: one input stage, 23 stages
// of the X and Z dividers (one quotient bit each), three matrix stages,
// 17 stages of the normalising dividers and three transfer curve stages.
// A new word is taken on every clock while the output is not stalled, so
// throughput is one pixel per cycle as long as m_tready stays high.
// All stages advance together: while the master side holds a word that is
// not taken, the whole pipeline and s_tready hold, and nothing is lost or
// repeated. When the output register is empty the pipeline moves freely.
// Reset clears the valid bits of all stages; the transfer curve table is a
// constant and needs no loading.
// ============================================================================
module cie_xy_to_srgb_color_top #(
    parameter int INPUT_FRAC_BITS       = cxs_pkg::INPUT_FRAC_BITS_DEF,
    parameter int GAMMA_TABLE_ADDR_BITS = cxs_pkg::GAMMA_ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // chroma_x [15:0], chroma_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red_level [7:0], green_level [15:8], blue_level [23:16]
);
    import cxs_pkg::*;

    localparam int MAG_W = mag_width(INPUT_FRAC_BITS);

    logic             en;
    logic             f_valid, f_white, f_zneg, f_xsat, f_zsat;
    logic [MAG_W-1:0] f_xmag, f_zmag;
    logic [15:0]      f_y;
    logic             dx_valid, dz_valid;
    logic [XZ_QW-1:0] dx_quo, dz_quo;
    logic [1:0]       dx_side, dz_side;
    logic             m_valid, m_white, m_norm;
    logic [LIN_W-1:0] m_r, m_g, m_b, m_max;
    logic             n_valid [3];
    logic [CH_W-1:0]  n_quo   [3];
    logic [CH_W-1:0]  n_side  [3];
    logic [1:0]       n_flags;
    logic [1:0]       n_flags_out;
    logic [LIN_W-1:0] ch_in   [3];
    logic [CH_W-1:0]  c_enc   [3];
    logic             g_valid [3];
    logic [7:0]       g_level [3];

    // The pipeline advances whenever the output register can take a word.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cxs_front #(
        .INPUT_FRAC_BITS (INPUT_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .chroma_x  (s_tdata[15:0]),
        .chroma_y  (s_tdata[31:16]),
        .out_valid (f_valid),
        .white     (f_white),
        .x_mag     (f_xmag),
        .z_mag     (f_zmag),
        .z_neg     (f_zneg),
        .x_sat     (f_xsat),
        .z_sat     (f_zsat),
        .y_val     (f_y)
    );

    // X = x / y and |Z| = |1-x-y| / y, quotient bits 22 down to 0.
    cxs_div_pipe #(
        .DIV_W  (16),
        .Q_W    (XZ_QW),
        .SIDE_W (2)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .rem0      (16'(f_xmag >> 7)),
        .bits      ({f_xmag[6:0], 16'b0}),
        .divisor   (f_y),
        .side_in   ({f_white, f_xsat}),
        .out_valid (dx_valid),
        .quotient  (dx_quo),
        .side_out  (dx_side)
    );

    cxs_div_pipe #(
        .DIV_W  (16),
        .Q_W    (XZ_QW),
        .SIDE_W (2)
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .rem0      (16'(f_zmag >> 7)),
        .bits      ({f_zmag[6:0], 16'b0}),
        .divisor   (f_y),
        .side_in   ({f_zsat, f_zneg}),
        .out_valid (dz_valid),
        .quotient  (dz_quo),
        .side_out  (dz_side)
    );

    cxs_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dx_valid && dz_valid),
        .white_in  (dx_side[1]),
        .x_quo     (dx_quo),
        .x_sat     (dx_side[0]),
        .z_quo     (dz_quo),
        .z_sat     (dz_side[1]),
        .z_neg     (dz_side[0]),
        .out_valid (m_valid),
        .white     (m_white),
        .do_norm   (m_norm),
        .ch_r      (m_r),
        .ch_g      (m_g),
        .ch_b      (m_b),
        .ch_max    (m_max)
    );

    assign ch_in[0] = m_r;
    assign ch_in[1] = m_g;
    assign ch_in[2] = m_b;
    assign n_flags  = {m_white, m_norm};

    // Normalisation c * 65536 / max, quotient bits 16 down to 0; the white
    // and rescale flags ride with the red lane.
    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [CH_W+1:0] side_o;

        cxs_div_pipe #(
            .DIV_W  (LIN_W),
            .Q_W    (CH_W),
            .SIDE_W (CH_W + 2)
        ) u_div_n (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (m_valid),
            .rem0      ({1'b0, ch_in[k][LIN_W-1:1]}),
            .bits      ({ch_in[k][0], 16'b0}),
            .divisor   (m_max),
            .side_in   ({n_flags, ch_in[k][CH_W-1:0]}),
            .out_valid (n_valid[k]),
            .quotient  (n_quo[k]),
            .side_out  (side_o)
        );

        assign n_side[k] = side_o[CH_W-1:0];
        if (k == 0)
        begin : g_flags
            assign n_flags_out = side_o[CH_W+1:CH_W];
        end

        assign c_enc[k] = n_flags_out[0] ? n_quo[k] : n_side[k];

        cxs_gamma #(
            .ADDR_BITS (GAMMA_TABLE_ADDR_BITS)
        ) u_gamma (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (n_valid[k]),
            .white_in  (n_flags_out[1]),
            .chan      (c_enc[k]),
            .out_valid (g_valid[k]),
            .level     (g_level[k])
        );
    end

    assign m_tvalid = g_valid[0] && g_valid[1] && g_valid[2];
    assign m_tdata  = {g_level[2], g_level[1], g_level[0]};

endmodule

/* rtl/cxs_front.sv */
// ============================================================================
// cxs_front
// Input stage: forms |1-x-y| and its sign, and flags quotients that will
// saturate the Q8.16 range.
// ============================================================================
module cxs_front #(
    parameter  int INPUT_FRAC_BITS = cxs_pkg::INPUT_FRAC_BITS_DEF,
    localparam int MAG_W           = cxs_pkg::mag_width(INPUT_FRAC_BITS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [15:0]      chroma_x,
    input  logic [15:0]      chroma_y,
    output logic             out_valid,
    output logic             white,
    output logic [MAG_W-1:0] x_mag,
    output logic [MAG_W-1:0] z_mag,
    output logic             z_neg,
    output logic             x_sat,
    output logic             z_sat,
    output logic [15:0]      y_val
);
    import cxs_pkg::*;

    localparam int N_W   = MAG_W + 1;
    localparam int CMP_W = (MAG_W > 23) ? MAG_W : 23;
    localparam logic [N_W-1:0] ONE_IN = N_W'(1) << INPUT_FRAC_BITS;

    logic [N_W-1:0]   n_u;
    logic [MAG_W-1:0] zm;
    logic [CMP_W-1:0] lim;
    logic             valid_reg;
    logic             white_reg, z_neg_reg, x_sat_reg, z_sat_reg;
    logic [MAG_W-1:0] x_mag_reg, z_mag_reg;
    logic [15:0]      y_reg;

    // A quotient reaches 2^23 exactly when the dividend is at least 128 * y.
    assign n_u = ONE_IN - N_W'(chroma_x) - N_W'(chroma_y);
    assign zm  = n_u[N_W-1] ? MAG_W'(-n_u) : n_u[MAG_W-1:0];
    assign lim = CMP_W'({chroma_y, 7'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            white_reg <= (chroma_y == 16'd0);
            x_mag_reg <= MAG_W'(chroma_x);
            z_mag_reg <= zm;
            z_neg_reg <= n_u[N_W-1];
            x_sat_reg <= CMP_W'(chroma_x) >= lim;
            z_sat_reg <= CMP_W'(zm) >= lim;
            y_reg     <= chroma_y;
        end
    end

    assign out_valid = valid_reg;
    assign white     = white_reg;
    assign x_mag     = x_mag_reg;
    assign z_mag     = z_mag_reg;
    assign z_neg     = z_neg_reg;
    assign x_sat     = x_sat_reg;
    assign z_sat     = z_sat_reg;
    assign y_val     = y_reg;

endmodule

/* rtl/cxs_div_pipe.sv */
// ============================================================================
// cxs_div_pipe
// Pipelined restoring divider: one quotient bit per register stage.
// ============================================================================
module cxs_div_pipe #(
    parameter int DIV_W  = 16,
    parameter int Q_W    = 23,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIV_W-1:0]  rem0,
    input  logic [Q_W-1:0]    bits,
    input  logic [DIV_W-1:0]  divisor,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quotient,
    output logic [SIDE_W-1:0] side_out
);
    import cxs_pkg::*;

    logic              valid_reg [Q_W];
    logic [DIV_W-1:0]  rem_reg   [Q_W];
    logic [Q_W-1:0]    quo_reg   [Q_W];
    logic [Q_W-1:0]    bits_reg  [Q_W];
    logic [DIV_W-1:0]  div_reg   [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        logic              v_in;
        logic [DIV_W-1:0]  rem_in, div_in;
        logic [Q_W-1:0]    quo_in, bits_in;
        logic [SIDE_W-1:0] side_v;
        logic [DIV_W:0]    r2;
        logic              ge;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = rem0;
            assign div_in  = divisor;
            assign quo_in  = '0;
            assign bits_in = bits;
            assign side_v  = side_in;
        end
        else
        begin : g_next
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign div_in  = div_reg[s-1];
            assign quo_in  = quo_reg[s-1];
            assign bits_in = bits_reg[s-1];
            assign side_v  = side_reg[s-1];
        end

        // Bring down the next dividend bit and try the subtraction.
        assign r2 = {rem_in, bits_in[Q_W-1-s]};
        assign ge = r2 >= {1'b0, div_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? DIV_W'(r2 - {1'b0, div_in}) : DIV_W'(r2);
                quo_reg[s]  <= Q_W'({quo_in, ge});
                bits_reg[s] <= bits_in;
                div_reg[s]  <= div_in;
                side_reg[s] <= side_v;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quotient  = quo_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

/* rtl/cxs_matrix.sv */
// ============================================================================
// cxs_matrix
// Saturates X and Z, applies the XYZ to linear RGB matrix, clamps negatives
// and finds the largest channel. Three register stages.
// ============================================================================
module cxs_matrix (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic                      white_in,
    input  logic [cxs_pkg::XZ_QW-1:0] x_quo,
    input  logic                      x_sat,
    input  logic [cxs_pkg::XZ_QW-1:0] z_quo,
    input  logic                      z_sat,
    input  logic                      z_neg,
    output logic                      out_valid,
    output logic                      white,
    output logic                      do_norm,
    output logic [cxs_pkg::LIN_W-1:0] ch_r,
    output logic [cxs_pkg::LIN_W-1:0] ch_g,
    output logic [cxs_pkg::LIN_W-1:0] ch_b,
    output logic [cxs_pkg::LIN_W-1:0] ch_max
);
    import cxs_pkg::*;

    logic signed [XZ_W-1:0]  x_s, z_s;
    logic [XZ_QW:0]          z_m;
    logic                    v1_reg, v2_reg, v3_reg;
    logic                    w1_reg, w2_reg, w3_reg;
    logic signed [SUM_W-1:0] pxr_reg, pxg_reg, pxb_reg, pzr_reg, pzg_reg, pzb_reg;
    logic signed [SUM_W-1:0] sr_reg, sg_reg, sb_reg;
    logic [LIN_W-1:0]        lr, lg, lb, mx;
    logic [LIN_W-1:0]        r3_reg, g3_reg, b3_reg, m3_reg;
    logic                    n3_reg;

    // Saturated X and Z in Q8.16.
    assign x_s = x_sat ? XZ_W'(24'h7FFFFF) : XZ_W'(x_quo);
    assign z_m = z_sat ? (z_neg ? 24'h800000 : 24'h7FFFFF) : {1'b0, z_quo};
    assign z_s = z_neg ? -$signed(XZ_W'(z_m)) : $signed(XZ_W'(z_m));

    // Clamp a Q32 sum to zero and drop to Q16.
    function automatic logic [LIN_W-1:0] lin_q16(input logic signed [SUM_W-1:0] s);
        return (s <= 0) ? '0 : s[16+LIN_W-1:16];
    endfunction

    assign lr = lin_q16(sr_reg);
    assign lg = lin_q16(sg_reg);
    assign lb = lin_q16(sb_reg);

    always_comb
    begin
        mx = lr;
        if (lg > mx)
        begin
            mx = lg;
        end
        if (lb > mx)
        begin
            mx = lb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Products, then sums, then clamp and maximum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg  <= white_in;
            pxr_reg <= SUM_W'(x_s * CR_X);
            pxg_reg <= SUM_W'(x_s * CG_X);
            pxb_reg <= SUM_W'(x_s * CB_X);
            pzr_reg <= SUM_W'(z_s * CR_Z);
            pzg_reg <= SUM_W'(z_s * CG_Z);
            pzb_reg <= SUM_W'(z_s * CB_Z);

            w2_reg  <= w1_reg;
            sr_reg  <= pxr_reg + pzr_reg + OFF_R;
            sg_reg  <= pxg_reg + pzg_reg + OFF_G;
            sb_reg  <= pxb_reg + pzb_reg + OFF_B;

            w3_reg  <= w2_reg;
            r3_reg  <= lr;
            g3_reg  <= lg;
            b3_reg  <= lb;
            m3_reg  <= mx;
            n3_reg  <= mx > LIN_W'(ONE_Q16);
        end
    end

    assign out_valid = v3_reg;
    assign white     = w3_reg;
    assign do_norm   = n3_reg;
    assign ch_r      = r3_reg;
    assign ch_g      = g3_reg;
    assign ch_b      = b3_reg;
    assign ch_max    = m3_reg;

endmodule

/* rtl/cxs_gamma.sv */
// ============================================================================
// cxs_gamma
// sRGB transfer curve for one channel: linear segment near black, table
// with linear interpolation elsewhere, then scaling to 8 bits; white gives 255.
// ============================================================================
module cxs_gamma #(
    parameter int ADDR_BITS = cxs_pkg::GAMMA_ADDR_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic                     white_in,
    input  logic [cxs_pkg::CH_W-1:0] chan,
    output logic                     out_valid,
    output logic [7:0]               level
);
    import cxs_pkg::*;

    localparam int SHIFT    = 16 - ADDR_BITS;
    localparam int ROM_SIZE = (1 << ADDR_BITS) + 1;
    localparam int IDX_W    = ADDR_BITS + 1;
    localparam int D_W      = 19 + SHIFT;
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(1) << ADDR_BITS;

    typedef logic [CH_W-1:0] rom_t [ROM_SIZE];

    function automatic rom_t build_rom();
        rom_t r;
        for (int i = 0; i < ROM_SIZE; i++)
        begin
            r[i] = gamma_entry(i, ADDR_BITS);
        end
        return r;
    endfunction

    localparam rom_t GAMMA_ROM = build_rom();

    logic [IDX_W-1:0]        idx, addr0, addr1;
    logic                    top;
    logic                    v1_reg, v2_reg, v3_reg;
    logic                    w1_reg, w2_reg;
    logic [CH_W-1:0]         e0_reg, e1_reg, c1_reg;
    logic [SHIFT-1:0]        f1_reg;
    logic                    lin1_reg, lin2_reg;
    logic signed [17:0]      diff;
    logic signed [D_W-1:0]   d_prod, dsh;
    logic signed [D_W-1:0]   d2_reg;
    logic [36:0]             lp2_reg;
    logic [CH_W-1:0]         e02_reg;
    logic signed [19:0]      v;
    logic [CH_W-1:0]         g, gc;
    logic [7:0]              level_reg;

    // Table addresses; at and above 1.0 both reads return the last entry.
    assign idx   = chan[16:SHIFT];
    assign top   = idx[ADDR_BITS];
    assign addr0 = top ? TOP_IDX : idx;
    assign addr1 = top ? TOP_IDX : idx + IDX_W'(1);

    assign diff   = $signed({1'b0, e1_reg}) - $signed({1'b0, e0_reg});
    assign d_prod = D_W'(diff * $signed({1'b0, f1_reg}));

    // Interpolated value, floored, then choose the segment and clamp.
    assign dsh = d2_reg >>> SHIFT;
    assign v   = $signed({3'b0, e02_reg}) + dsh[19:0];

    always_comb
    begin
        if (lin2_reg)
        begin
            g = CH_W'(lp2_reg >> 16);
        end
        else if (v < 0)
        begin
            g = '0;
        end
        else
        begin
            g = (v > $signed({3'b0, ONE_Q16})) ? ONE_Q16 : v[CH_W-1:0];
        end
        gc = (g > ONE_Q16) ? ONE_Q16 : g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Table read.
            e0_reg   <= GAMMA_ROM[addr0];
            e1_reg   <= GAMMA_ROM[addr1];
            c1_reg   <= chan;
            f1_reg   <= chan[SHIFT-1:0];
            lin1_reg <= chan <= LIN_LIMIT;
            w1_reg   <= white_in;

            // Interpolation product and linear segment product.
            d2_reg   <= d_prod;
            lp2_reg  <= 37'(c1_reg * LIN_SLOPE);
            e02_reg  <= e0_reg;
            lin2_reg <= lin1_reg;
            w2_reg   <= w1_reg;

            // Scale by 255 and truncate.
            level_reg <= w2_reg ? 8'd255 : 8'((({gc, 8'b0} - 25'(gc)) >> 16));
        end
    end

    assign out_valid = v3_reg;
    assign level     = level_reg;

endmodule
